// ===== rtl/anr_pkg.sv =====
package anr_pkg;

  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned HALF_W    = 23;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FRAC_W    = FRAC_BITS + 1;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic {
    F_IDLE,
    F_UPD
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic primed;
    logic run_div;
  } job_ctrl_t;

endpackage

// ===== rtl/auto_range_normalizer.sv =====
// Per-channel auto-range normalizer. Each sample_i tagged with channel_i is placed within
// that channel's running [lower, upper] range and answered as a Q1.16 fraction (65536 means
// the upper bound); the first sample of a channel seeds the range at sample +/- the half
// width written on cfg_wdata_i and answers 0 with primed_o low. A front stage reads and
// updates the per-channel bounds in a small RAM and hands a job to a 2-entry queue; the back
// stage runs a restoring divider at one quotient bit per cycle. A transaction that divides
// passes in the back stage through a fetch, 17 divide steps and a result load, and the back
// stage fetches no new job before the load; one that skips the divide goes from fetch to load.
// Channels at or above NUM_CHANNELS change no state and answer 0 with primed_o low.
module auto_range_normalizer
  import anr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [HALF_W-1:0]             cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [CHAN_W-1:0]             channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FRAC_W-1:0]             fraction_o,
  output logic                          primed_o
);

  localparam int unsigned BOUND_W = ((SAMPLE_BITS > HALF_W + 1) ? SAMPLE_BITS : HALF_W + 1) + 1;
  localparam int unsigned JOB_W   = $bits(job_ctrl_t) + 2 * BOUND_W;
  localparam int unsigned QDEPTH  = 2;

  logic [HALF_W-1:0] start_half_width_q;
  logic              push, pop, full, empty;
  logic [JOB_W-1:0]  job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_half_width_q <= '0;
    end else if (cfg_we_i) begin
      start_half_width_q <= cfg_wdata_i;
    end
  end

  anr_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BOUND_W     (BOUND_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .half_width_i(start_half_width_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  anr_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(empty)
  );

  anr_back #(
    .BOUND_W(BOUND_W),
    .JOB_W  (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .fraction_o (fraction_o),
    .primed_o   (primed_o)
  );

endmodule

// ===== rtl/anr_ram.sv =====
module anr_ram #(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/anr_fifo.sv =====
module anr_fifo #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== rtl/anr_front.sv =====
module anr_front
  import anr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned BOUND_W      = 25,
  parameter int unsigned JOB_W        = 52
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [HALF_W-1:0]             half_width_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [CHAN_W-1:0]             channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          push_o,
  output logic [JOB_W-1:0]              job_o,
  input  logic                          full_i
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  front_state_e state_q, state_d;

  logic [IDX_W-1:0]              idx_q;
  logic                          in_range_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [NUM_CHANNELS-1:0]       seen_q;

  logic                      accept;
  logic [IDX_W-1:0]          raddr;
  logic [2*BOUND_W-1:0]      rdata;
  logic                      ram_we;
  logic                      seen_rd;
  logic signed [BOUND_W-1:0] s_ext, hw_ext, lo_rd, hi_rd, lo_n, hi_n;
  logic [BOUND_W-1:0]        range, pos;
  job_ctrl_t                 ctrl;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_UPD;
      F_UPD:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: in_ready_o = 1'b1;
      F_UPD:  push_o = !full_i;
      default: begin
        in_ready_o = 1'b0;
        push_o     = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign ram_we = push_o && in_range_q;
  assign raddr  = (state_q == F_IDLE) ? IDX_W'(channel_i) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        seen_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q      <= IDX_W'(channel_i);
      in_range_q <= ({24'd0, channel_i} < 28'(NUM_CHANNELS));
      sample_q   <= sample_i;
    end
  end

  anr_ram #(
    .WIDTH(2 * BOUND_W),
    .DEPTH(NUM_CHANNELS)
  ) u_bounds (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i({hi_n, lo_n}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign seen_rd = seen_q[idx_q];
  assign s_ext   = {{(BOUND_W - SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign hw_ext  = {{(BOUND_W - HALF_W){1'b0}}, half_width_i};
  assign lo_rd   = rdata[BOUND_W-1:0];
  assign hi_rd   = rdata[2*BOUND_W-1:BOUND_W];

  always_comb begin
    if (seen_rd) begin
      lo_n = (s_ext < lo_rd) ? s_ext : lo_rd;
      hi_n = (s_ext > hi_rd) ? s_ext : hi_rd;
    end else begin
      lo_n = s_ext - hw_ext;
      hi_n = s_ext + hw_ext;
    end
  end

  assign range        = hi_n - lo_n;
  assign pos          = s_ext - lo_n;
  assign ctrl.primed  = in_range_q && seen_rd;
  assign ctrl.run_div = in_range_q && seen_rd && (range != '0);
  assign job_o        = {ctrl, pos, range};

  a_bounds_hold_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_UPD && in_range_q && seen_rd) |-> (lo_n <= s_ext && s_ext <= hi_n))
    else $error("updated bounds do not enclose sample");

endmodule

// ===== rtl/anr_back.sv =====
module anr_back
  import anr_pkg::*;
#(
  parameter int unsigned BOUND_W = 25,
  parameter int unsigned JOB_W   = 52
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  logic [JOB_W-1:0]  job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FRAC_W-1:0] fraction_o,
  output logic              primed_o
);

  localparam int unsigned REM_W = BOUND_W + 1;

  back_state_e state_q, state_d;

  job_ctrl_t          job_ctrl;
  logic [BOUND_W-1:0] job_pos, job_range;

  logic [REM_W-1:0]   rem_q;
  logic [BOUND_W-1:0] range_q;
  logic [FRAC_W-1:0]  quot_q;
  logic [STEP_W-1:0]  step_q;
  logic               primed_q;
  logic               run_q;

  logic               out_valid_q;
  logic [FRAC_W-1:0]  fraction_q;
  logic               out_primed_q;

  logic               last_step;
  logic               load_out;
  logic [REM_W-1:0]   trial, range_ext;
  logic               ge;

  assign {job_ctrl, job_pos, job_range} = job_i;

  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!empty_i) state_d = job_ctrl.run_div ? B_DIV : B_DONE;
      B_DIV:  if (last_step) state_d = B_DONE;
      B_DONE: if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      B_IDLE: pop_o = !empty_i;
      B_DIV:  pop_o = 1'b0;
      B_DONE: load_out = !out_valid_q || out_ready_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign range_ext = {1'b0, range_q};
  assign trial     = (step_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
  assign ge        = (trial >= range_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q    <= {1'b0, job_pos};
      range_q  <= job_range;
      quot_q   <= '0;
      step_q   <= '0;
      primed_q <= job_ctrl.primed;
      run_q    <= job_ctrl.run_div;
    end else if (state_q == B_DIV) begin
      rem_q  <= ge ? trial - range_ext : trial;
      quot_q <= {quot_q[FRAC_W-2:0], ge};
      step_q <= step_q + STEP_W'(1);
    end
    if (load_out) begin
      fraction_q   <= run_q ? quot_q : '0;
      out_primed_q <= primed_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fraction_o  = fraction_q;
  assign primed_o    = out_primed_q;

  a_rem_below_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && step_q != '0) |-> (rem_q < range_ext))
    else $error("divider remainder not reduced");

  a_fraction_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fraction_q <= FRAC_W'(1 << FRAC_BITS)))
    else $error("fraction above one");

  a_unprimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_primed_q) |-> (fraction_q == '0))
    else $error("first sample with nonzero fraction");

endmodule
